[sv/sdf_pkg.sv]
`default_nettype none

package sdf_pkg;

  // Field widths of the two channels and the configuration register.
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 6;
  localparam int INDEX_W  = 5;
  localparam int HLEN_W   = 8;
  localparam int COUNT_W  = 6;

  // A frame carries at most this many payload bytes, whatever the store depth.
  localparam int RUN_LIMIT = 32;

  localparam int PAYLOAD_DEPTH_DEF = 32;

  localparam logic [BYTE_W-1:0] START_CODE    = 8'hCA;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 6'd32;

  typedef enum logic [2:0] {
    ST_HUNT     = 3'd0,
    ST_OPCODE   = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_DATA     = 3'd3,
    ST_CHECK    = 3'd4,
    ST_EMIT_RD  = 3'd5,
    ST_EMIT_OUT = 3'd6
  } sdf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic frame_clear;
    logic take_opcode;
    logic take_length;
    logic take_data;
    logic emit_start;
    logic mem_read;
    logic emit_next;
  } sdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_seen;
    logic data_reject;
    logic data_final;
    logic sum_match;
    logic emit_last;
  } sdf_stat_t;

endpackage

`default_nettype wire

[sv/sdf_rx_if.sv]
`default_nettype none

interface sdf_rx_if
  import sdf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/sdf_frame_if.sv]
`default_nettype none

interface sdf_frame_if
  import sdf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  frame_opcode;
  logic [LEN_W-1:0]   frame_length;
  logic [BYTE_W-1:0]  payload_byte;
  logic [INDEX_W-1:0] byte_index;
  logic               last_byte;

  modport source (output valid, output frame_opcode, output frame_length,
                  output payload_byte, output byte_index, output last_byte,
                  input ready);
  modport sink   (input valid, input frame_opcode, input frame_length,
                  input payload_byte, input byte_index, input last_byte,
                  output ready);
endinterface

`default_nettype wire

[sv/sdf_ctrl.sv]
`default_nettype none

module sdf_ctrl
  import sdf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire sdf_stat_t stat,
  output sdf_cmd_t       cmd
);

  sdf_state_t state_r;
  sdf_state_t state_nxt;
  logic       acc;
  logic       out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_ready  = (state_r inside {ST_HUNT, ST_OPCODE, ST_LENGTH, ST_DATA, ST_CHECK});
    out_valid = (state_r == ST_EMIT_OUT);
  end

  assign acc      = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (acc && stat.start_seen) state_nxt = ST_OPCODE;
      end
      ST_OPCODE: begin
        if (acc) state_nxt = ST_LENGTH;
      end
      ST_LENGTH: begin
        if (acc) state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (acc) begin
          if (stat.data_reject) state_nxt = ST_HUNT;
          else if (stat.data_final) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (acc) state_nxt = stat.sum_match ? ST_EMIT_RD : ST_HUNT;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_take) state_nxt = stat.emit_last ? ST_HUNT : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_HUNT:     cmd.frame_clear = acc && stat.start_seen;
      ST_OPCODE:   cmd.take_opcode = acc;
      ST_LENGTH:   cmd.take_length = acc;
      ST_DATA:     cmd.take_data   = acc && !stat.data_reject;
      ST_CHECK:    cmd.emit_start  = acc && stat.sum_match;
      ST_EMIT_RD:  cmd.mem_read    = 1'b1;
      ST_EMIT_OUT: cmd.emit_next   = out_take && !stat.emit_last;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/sdf_dp.sv]
`default_nettype none

module sdf_dp
  import sdf_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [LEN_W-1:0]   cfg_wdata,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  input  wire sdf_cmd_t           cmd,
  output sdf_stat_t               stat,
  output logic [BYTE_W-1:0]       frame_opcode,
  output logic [LEN_W-1:0]        frame_length,
  output logic [BYTE_W-1:0]       payload_byte,
  output logic [INDEX_W-1:0]      byte_index,
  output logic                    last_byte
);

  // Frames longer than the run limit are never kept, so the store needs no more.
  localparam int STORE_DEPTH = (PAYLOAD_DEPTH < RUN_LIMIT) ? PAYLOAD_DEPTH : RUN_LIMIT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [LEN_W-1:0]   LIMIT_CAP = LEN_W'(STORE_DEPTH);
  localparam logic [COUNT_W-1:0] STORE_TOP = COUNT_W'(STORE_DEPTH);

  logic [LEN_W-1:0]   max_length_r;
  logic [BYTE_W-1:0]  held_opcode_r;
  logic [HLEN_W-1:0]  held_length_r;
  logic [COUNT_W-1:0] byte_count_r;
  logic [BYTE_W-1:0]  running_sum_r;
  logic [INDEX_W-1:0] idx_r;
  logic [BYTE_W-1:0]  rd_data_r;
  logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];

  logic [LEN_W-1:0]   limit;

  always_comb begin
    limit = (max_length_r > LIMIT_CAP) ? LIMIT_CAP : max_length_r;
    stat.start_seen  = (rx_byte == START_CODE);
    stat.data_reject = ({2'b00, byte_count_r} >= held_length_r) ||
                       (held_length_r > {2'b00, limit});
    stat.data_final  = (({2'b00, byte_count_r} + 8'd1) == held_length_r);
    stat.sum_match   = (running_sum_r == rx_byte);
    stat.emit_last   = (({3'b000, idx_r} + 8'd1) == held_length_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r  <= MAX_LENGTH_RST;
      held_opcode_r <= '0;
      held_length_r <= '0;
      byte_count_r  <= '0;
      running_sum_r <= '0;
      idx_r         <= '0;
    end else begin
      if (cfg_we) max_length_r <= cfg_wdata;
      if (cmd.frame_clear) begin
        held_length_r <= '0;
        byte_count_r  <= '0;
        running_sum_r <= '0;
      end
      if (cmd.take_opcode) held_opcode_r <= rx_byte;
      if (cmd.take_length) held_length_r <= rx_byte;
      if (cmd.take_data) begin
        running_sum_r <= running_sum_r + rx_byte;
        byte_count_r  <= byte_count_r + 6'd1;
      end
      if (cmd.emit_start) idx_r <= '0;
      else if (cmd.emit_next) idx_r <= idx_r + 5'd1;
    end
  end

  // Payload store: one write port from the parser, one registered read port for emission.
  always_ff @(posedge clk) begin
    if (cmd.take_data && (byte_count_r < STORE_TOP)) begin
      store_mem[byte_count_r[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.mem_read) begin
      rd_data_r <= store_mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_comb begin
    frame_opcode = held_opcode_r;
    frame_length = held_length_r[LEN_W-1:0];
    payload_byte = rd_data_r;
    byte_index   = idx_r;
    last_byte    = stat.emit_last;
  end

endmodule

`default_nettype wire

[sv/start_code_frame_deframer_unit.sv]
`default_nettype none

// Channel     Dir   Beat contents
// in_rx       in    rx_byte: one received byte of the serial stream
// out_frame   out   frame_opcode, frame_length, payload_byte, byte_index, last_byte
// cfg_*       in    max_length, written when cfg_we is high
//
// The parser accepts a byte every cycle while it is hunting or collecting a
// frame. After a good checksum the input stops and the payload is replayed
// from the store, each beat first read from the store and then presented,
// and held while out_frame stalls. Synchronous active-low reset puts the
// parser back to hunting for the start code and max_length back to 32.

module start_code_frame_deframer_unit
  import sdf_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  sdf_rx_if.sink                in_rx,
  sdf_frame_if.source           out_frame,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata
);

  sdf_cmd_t  cmd;
  sdf_stat_t stat;

  // The controller owns the parse phase and the emission sequence; the
  // datapath holds the frame header, the running checksum and the payload store.
  sdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_rx.valid),
    .in_ready  (in_rx.ready),
    .out_valid (out_frame.valid),
    .out_ready (out_frame.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdf_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (in_rx.rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .frame_opcode (out_frame.frame_opcode),
    .frame_length (out_frame.frame_length),
    .payload_byte (out_frame.payload_byte),
    .byte_index   (out_frame.byte_index),
    .last_byte    (out_frame.last_byte)
  );

endmodule

`default_nettype wire
